// ===== hw/rtl/lmr_pkg.sv =====
// Shared types, codes and helpers for the LIN master response receiver.
// No dependencies; used by lmr_frame_fsm, lmr_result_fifo and the top level.
`timescale 1ns / 1ps

package lmr_pkg;

  // Field widths
  localparam int unsigned ReqW    = 2;
  localparam int unsigned IdW     = 6;
  localparam int unsigned LenW    = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SeenW   = 4;
  localparam int unsigned TickW   = 16;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // Largest response accepted; longer requests saturate to it
  localparam logic [LenW-1:0] MaxDataBytes = 4'd8;

  localparam logic [ByteW-1:0] SyncByte     = 8'h55;
  localparam logic [TickW-1:0] TickMax      = 16'hFFFF;
  localparam logic [TickW-1:0] TimeoutReset = 16'd174;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_BREAK = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  // Frame status on done
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNoSync   = 3'd1;
  localparam logic [StatusW-1:0] StNoId     = 3'd2;
  localparam logic [StatusW-1:0] StTimeout  = 3'd3;
  localparam logic [StatusW-1:0] StChecksum = 3'd4;

  // Frame phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC  = 3'd1,
    PH_ID    = 3'd2,
    PH_DATA  = 3'd3,
    PH_CKSUM = 3'd4
  } phase_e;

  // One result item
  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   data;
    logic [IndexW-1:0]  index;
    logic [StatusW-1:0] status;
    logic [SeenW-1:0]   seen;
    logic               last;
  } res_t;

  // Results raised by one transfer, slot 0 first
  typedef struct packed {
    logic [1:0]      num;
    res_t [2:0]      item;
  } push_t;

  // Protected id: id bits plus the two LIN parity bits
  function automatic logic [ByteW-1:0] make_pid(logic [IdW-1:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Ones-complement add with end-around carry
  function automatic logic [ByteW-1:0] oc_add(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
  endfunction

endpackage

// ===== hw/rtl/lmr_frame_fsm.sv =====
// Frame sequencer: phase, checksum, byte count and timeout state.
// Turns each accepted request into up to three results. Depends on lmr_pkg.
`timescale 1ns / 1ps

module lmr_frame_fsm import lmr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TickW-1:0]    cfg_data_i,
  input  logic                acc_i,
  input  req_e                req_i,
  input  logic [IdW-1:0]      frame_id_i,
  input  logic [LenW-1:0]     data_len_i,
  input  logic                classic_i,
  input  logic [ByteW-1:0]    rx_byte_i,
  output push_t               push_o
);

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  pid_q, pid_d;
  logic [LenW-1:0]   exp_len_q, exp_len_d;
  logic [SeenW-1:0]  rcount_q, rcount_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic              classic_q, classic_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [TickW-1:0]  timeout_q;

  logic [ByteW-1:0]  new_pid;
  logic [SeenW-1:0]  rcount_inc;
  logic [TickW-1:0]  tick_inc;
  logic [StatusW-1:0] tmo_status;

  assign new_pid    = make_pid(frame_id_i);
  assign rcount_inc = rcount_q + 4'd1;
  assign tick_inc   = (tick_q != TickMax) ? tick_q + 16'd1 : tick_q;

  always_comb begin
    case (phase_q)
      PH_SYNC: tmo_status = StNoSync;
      PH_ID:   tmo_status = StNoId;
      default: tmo_status = StTimeout;
    endcase
  end

  // Next state
  always_comb begin
    phase_d   = phase_q;
    pid_d     = pid_q;
    exp_len_d = exp_len_q;
    rcount_d  = rcount_q;
    sum_d     = sum_q;
    classic_d = classic_q;
    tick_d    = tick_q;
    if (acc_i) begin
      unique case (req_i)
        REQ_START: begin
          pid_d     = new_pid;
          exp_len_d = (data_len_i > MaxDataBytes) ? MaxDataBytes : data_len_i;
          rcount_d  = '0;
          classic_d = classic_i;
          sum_d     = classic_i ? '0 : new_pid;
          tick_d    = '0;
          phase_d   = PH_SYNC;
        end
        REQ_BYTE: begin
          unique case (phase_q)
            PH_SYNC: if (rx_byte_i == SyncByte) phase_d = PH_ID;
            PH_ID: begin
              if (rx_byte_i == pid_q) phase_d = (exp_len_q == '0) ? PH_CKSUM : PH_DATA;
            end
            PH_DATA: begin
              sum_d    = oc_add(sum_q, rx_byte_i);
              rcount_d = rcount_inc;
              if (rcount_inc >= exp_len_q) phase_d = PH_CKSUM;
            end
            PH_CKSUM: begin
              rcount_d = rcount_inc;
              phase_d  = PH_IDLE;
            end
            default: ;
          endcase
        end
        REQ_TICK: begin
          if (phase_q != PH_IDLE) begin
            tick_d = tick_inc;
            if (tick_inc >= timeout_q) phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Result outputs
  always_comb begin
    push_o = '0;
    if (acc_i) begin
      unique case (req_i)
        REQ_START: begin
          push_o.num          = 2'd3;
          push_o.item[0].kind = KIND_BREAK;
          push_o.item[1].kind = KIND_SEND;
          push_o.item[1].data = SyncByte;
          push_o.item[2].kind = KIND_SEND;
          push_o.item[2].data = new_pid;
          push_o.item[2].last = 1'b1;
        end
        REQ_BYTE: begin
          if (phase_q == PH_DATA) begin
            push_o.num           = 2'd1;
            push_o.item[0].kind  = KIND_DATA;
            push_o.item[0].data  = rx_byte_i;
            push_o.item[0].index = rcount_q[IndexW-1:0];
            push_o.item[0].last  = 1'b1;
          end else if (phase_q == PH_CKSUM) begin
            push_o.num            = 2'd1;
            push_o.item[0].kind   = KIND_DONE;
            push_o.item[0].status = (~sum_q == rx_byte_i) ? StOk : StChecksum;
            push_o.item[0].seen   = rcount_inc;
            push_o.item[0].last   = 1'b1;
          end
        end
        REQ_TICK: begin
          if (phase_q != PH_IDLE && tick_inc >= timeout_q) begin
            push_o.num            = 2'd1;
            push_o.item[0].kind   = KIND_DONE;
            push_o.item[0].status = tmo_status;
            push_o.item[0].seen   = rcount_q;
            push_o.item[0].last   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pid_q     <= '0;
      exp_len_q <= '0;
      rcount_q  <= '0;
      sum_q     <= '0;
      classic_q <= 1'b0;
      tick_q    <= '0;
      timeout_q <= TimeoutReset;
    end else begin
      phase_q   <= phase_d;
      pid_q     <= pid_d;
      exp_len_q <= exp_len_d;
      rcount_q  <= rcount_d;
      sum_q     <= sum_d;
      classic_q <= classic_d;
      tick_q    <= tick_d;
      if (cfg_we_i) timeout_q <= cfg_data_i;
    end
  end

endmodule

// ===== hw/rtl/lmr_result_fifo.sv =====
// Four-entry result queue: takes up to three results a cycle, gives one while ready_i is high.
// Depends on lmr_pkg.
`timescale 1ns / 1ps

module lmr_result_fifo import lmr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   room_o,   // space for a full start burst after this cycle's pop
  output logic   valid_o,
  input  logic   ready_i,
  output res_t   head_o
);

  res_t       mem [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] count_q;
  logic       pop;

  assign valid_o = (count_q != 3'd0);
  assign pop     = valid_o && ready_i;
  assign head_o  = mem[rd_q];
  assign room_o  = (count_q - {2'b00, pop}) <= 3'd1;

  // Storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_i.num) mem[wr_q + 2'(i)] <= push_i.item[i];
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + push_i.num;
      rd_q    <= rd_q + {1'b0, pop};
      count_q <= count_q + {1'b0, push_i.num} - {2'b00, pop};
    end
  end

endmodule

// ===== hw/rtl/lin_master_response_receiver.sv =====
// Top level of the LIN master response receiver: stream ports, config write.
// Instantiates lmr_frame_fsm and lmr_result_fifo; depends on lmr_pkg.
//
//   channel  | direction | carries
//   ---------+-----------+-------------------------------------------------
//   s_axis   | in        | requests: start, bus byte, 100 us tick
//   m_axis   | out       | break / send byte / data byte / frame done
//   cfg      | in        | timeout_ticks write
//
// Each request is handled in the cycle it is accepted; results enter a
// four-entry queue and leave one per cycle while m_axis_tready is high,
// so a start raises three results, other requests at most one.
// s_axis_tready is high while the queue can take a full start burst.
// Reset empties the queue and returns the frame phase to idle; cfg is
// always ready.
`timescale 1ns / 1ps

module lin_master_response_receiver import lmr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [5:0] frame_id, [9:6] data_len, [10] classic_checksum, [18:11] rx_byte
  input  logic [InDataW-1:0]   s_axis_tdata,
  // [1:0] req_type
  input  logic [ReqW-1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] out_byte, [10:8] out_index, [13:11] status, [17:14] bytes_seen
  output logic [OutDataW-1:0]  m_axis_tdata,
  // [1:0] out_kind
  output logic [KindW-1:0]     m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TickW-1:0]     cfg_data_i
);

  logic  in_acc;
  push_t push;
  res_t  head;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  lmr_frame_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .acc_i      (in_acc),
    .req_i      (req_e'(s_axis_tuser)),
    .frame_id_i (s_axis_tdata[5:0]),
    .data_len_i (s_axis_tdata[9:6]),
    .classic_i  (s_axis_tdata[10]),
    .rx_byte_i  (s_axis_tdata[18:11]),
    .push_o     (push)
  );

  lmr_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  // Output packing
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {6'd0, head.seen, head.status, head.index, head.data};

  // A start always shows a result in the next cycle
  a_start_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser == REQ_START |=> m_axis_tvalid)
    else $error("start accepted but no result followed");

  // A break is never the last result of its request
  a_break_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_BREAK |-> !m_axis_tlast)
    else $error("break marked as last");

  // Frame done always closes its request
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tlast)
    else $error("done result without last");

  // Break transfer is directly followed by the sync byte
  a_break_then_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_BREAK |=>
      m_axis_tvalid && m_axis_tuser == KIND_SEND && m_axis_tdata[7:0] == SyncByte)
    else $error("break not followed by sync byte");

endmodule
